// ----- design/irea_pkg.sv -----
// Shared types and constants for the interval-rated energy accumulator.
// Used by the controller, the datapath and the top level. No dependencies.
package irea_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_READ   = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    localparam logic CFG_WINDOW_START = 1'b0;
    localparam logic CFG_WINDOW_END   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_HIT_RD,
        ST_HIT_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_DIV_WAIT,
        ST_REPORT,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // write the interval table
        logic check;      // evaluate reading pre-conditions
        logic rd_hit;     // read table at last hit
        logic rd_scan;    // read table at scan index
        logic scan_clr;   // reset scan index
        logic scan_inc;   // advance scan index
        logic set_hit;    // last hit takes scan index
        logic mul;        // form products
        logic acc;        // add products into sums
        logic reject;     // count a rejected row
        logic move_prev;  // previous time takes reading time
        logic div_start;  // start both divisions
        logic report;     // build the result item
        logic clear;      // clear the run
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rej_time;   // time field missing
        logic ignore;     // zero time or outside the window
        logic prev_only;  // no previous time or non-positive gap
        logic rej_field;  // energy or temperature missing
        logic hit_ok;     // last hit indexes a loaded entry
        logic match;      // table entry read covers the reading time
        logic scan_end;   // scan index has reached the loaded count
        logic div_done;   // both divisions finished
    } t_status;

endpackage

// ----- design/irea_div.sv -----
// Radix-2 restoring divider for signed 64 by 64 bit quotients, truncating.
// Depends on nothing else; used twice by the datapath.
module irea_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quo
);
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [64:0] r_rem;
    logic [63:0] r_d;
    logic        r_neg;
    logic        r_done;
    logic [64:0] w_sh;
    logic [64:0] w_sub;
    logic [63:0] w_an;
    logic [63:0] w_ad;

    assign w_an  = i_num[63] ? 64'(-i_num) : i_num;
    assign w_ad  = i_den[63] ? 64'(-i_den) : i_den;
    assign w_sh  = {r_rem[63:0], r_q[63]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
            r_q    <= w_an;
            r_rem  <= '0;
            r_d    <= w_ad;
            r_neg  <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            if (!w_sub[64]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[62:0], 1'b0};
            end
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? 64'(-r_q) : r_q;
endmodule

// ----- design/irea_ctrl.sv -----
// Controller state machine of the interval-rated energy accumulator.
// Depends on irea_pkg for the state, command and status types.
module irea_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  irea_pkg::t_status i_status,
    output irea_pkg::t_cmd    o_cmd
);
    irea_pkg::t_state r_state, n_state;
    logic             w_take;

    assign o_in_ready = (r_state == irea_pkg::ST_IDLE);
    assign w_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= irea_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_out_valid = 1'b0;
        case (r_state)
            irea_pkg::ST_IDLE: begin
                if (w_take) begin
                    case (i_mode)
                        irea_pkg::MODE_LOAD:   n_state = irea_pkg::ST_LOAD;
                        irea_pkg::MODE_READ:   n_state = irea_pkg::ST_CHECK;
                        irea_pkg::MODE_FINISH: n_state = irea_pkg::ST_DIV;
                        default:               n_state = irea_pkg::ST_IDLE;
                    endcase
                end
            end
            irea_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = irea_pkg::ST_IDLE;
            end
            irea_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_status.rej_time) begin
                    o_cmd.reject = 1'b1;
                    n_state      = irea_pkg::ST_IDLE;
                end else if (i_status.ignore) begin
                    n_state = irea_pkg::ST_IDLE;
                end else if (i_status.prev_only) begin
                    o_cmd.move_prev = 1'b1;
                    n_state         = irea_pkg::ST_IDLE;
                end else if (i_status.rej_field) begin
                    o_cmd.reject    = 1'b1;
                    o_cmd.move_prev = 1'b1;
                    n_state         = irea_pkg::ST_IDLE;
                end else if (i_status.hit_ok) begin
                    o_cmd.rd_hit = 1'b1;
                    n_state      = irea_pkg::ST_HIT_RD;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = irea_pkg::ST_SCAN_RD;
                end
            end
            irea_pkg::ST_HIT_RD: n_state = irea_pkg::ST_HIT_CMP;
            irea_pkg::ST_HIT_CMP: begin
                if (i_status.match) begin
                    n_state = irea_pkg::ST_MUL;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = irea_pkg::ST_SCAN_RD;
                end
            end
            irea_pkg::ST_SCAN_RD: begin
                if (i_status.scan_end) begin
                    o_cmd.reject    = 1'b1;
                    o_cmd.move_prev = 1'b1;
                    n_state         = irea_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = irea_pkg::ST_SCAN_CMP;
                end
            end
            irea_pkg::ST_SCAN_CMP: begin
                if (i_status.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = irea_pkg::ST_MUL;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = irea_pkg::ST_SCAN_RD;
                end
            end
            irea_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = irea_pkg::ST_ACC;
            end
            irea_pkg::ST_ACC: begin
                o_cmd.acc       = 1'b1;
                o_cmd.move_prev = 1'b1;
                n_state         = irea_pkg::ST_IDLE;
            end
            irea_pkg::ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = irea_pkg::ST_DIV_WAIT;
            end
            irea_pkg::ST_DIV_WAIT: begin
                if (i_status.div_done) n_state = irea_pkg::ST_REPORT;
            end
            irea_pkg::ST_REPORT: begin
                o_cmd.report = 1'b1;
                o_cmd.clear  = 1'b1;
                n_state      = irea_pkg::ST_OUT;
            end
            irea_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = irea_pkg::ST_IDLE;
            end
            default: n_state = irea_pkg::ST_IDLE;
        endcase
    end

    // A result item is only offered after a finish request.
    a_out_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.report))
        else $error("result offered without report");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");
    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |-> $past(o_cmd.mul))
        else $error("accumulate without product");
endmodule

// ----- design/irea_dp.sv -----
// Datapath: interval table memory, window checks, sums, divisions, result.
// Depends on irea_pkg and irea_div.
module irea_dp #(
    parameter int TABLE_DEPTH = 128,
    parameter int TIME_BITS   = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [TIME_BITS-1:0] i_interval_start,
    input  logic [TIME_BITS-1:0] i_interval_end,
    input  logic [23:0]          i_interval_rate,
    input  logic [TIME_BITS-1:0] i_reading_time,
    input  logic                 i_time_present,
    input  logic signed [31:0]   i_reading_energy,
    input  logic                 i_energy_present,
    input  logic signed [15:0]   i_reading_temp,
    input  logic                 i_temp_present,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [39:0]          i_cfg_data,
    input  irea_pkg::t_cmd       i_cmd,
    output irea_pkg::t_status    o_status,
    output logic [255:0]         o_result
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [47:0] E_MAX  = 48'h7FFF_FFFF_FFFF;

    logic [TIME_BITS-1:0] r_mem_b [TABLE_DEPTH];
    logic [TIME_BITS-1:0] r_mem_e [TABLE_DEPTH];
    logic [23:0]          r_mem_r [TABLE_DEPTH];
    logic [TIME_BITS-1:0] r_rd_b, r_rd_e;
    logic [23:0]          r_rd_r;

    logic [CW-1:0] r_loaded;
    logic [AW-1:0] r_hit;
    logic [CW-1:0] r_scan;
    logic [TIME_BITS-1:0] r_prev;
    logic [39:0] r_win_s, r_win_e;

    logic [TIME_BITS-1:0] r_t, r_ib, r_ie;
    logic [23:0]          r_ir;
    logic                 r_tp, r_ep, r_pp;
    logic signed [31:0]   r_en;
    logic signed [15:0]   r_tm;

    logic signed [47:0] r_esum;
    logic signed [63:0] r_msum, r_wsum;
    logic [47:0]        r_elap;
    logic [31:0]        r_acnt, r_rcnt;
    logic signed [63:0] r_pe, r_pt;
    logic [47:0]        r_gap;

    logic [255:0] r_res;

    logic [TIME_BITS-1:0] w_tw, w_sw, w_ew, w_gapf;
    logic [47:0]          w_gap;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_rd;

    always_comb begin
        w_sw  = TIME_BITS'(r_win_s);
        w_ew  = TIME_BITS'(r_win_e);
        w_tw  = r_t;
        w_gapf = r_t - r_prev;
    end

    if (TIME_BITS > 47) begin : g_gap_wide
        assign w_gap = (w_gapf > TIME_BITS'(E_MAX)) ? E_MAX : w_gapf[47:0];
    end else begin : g_gap_nar
        assign w_gap = 48'(w_gapf);
    end

    assign o_status.rej_time  = !r_tp;
    assign o_status.ignore    = (w_tw == '0) || (w_tw < w_sw) || (w_tw > w_ew);
    assign o_status.prev_only = (r_prev == '0) || (w_tw <= r_prev);
    assign o_status.rej_field = !r_ep || !r_pp;
    assign o_status.hit_ok    = (CW'(r_hit) < r_loaded);
    assign o_status.match     = (w_tw >= r_rd_b) && (w_tw < r_rd_e);
    assign o_status.scan_end  = (r_scan >= r_loaded);

    assign w_rd      = i_cmd.rd_hit || i_cmd.rd_scan;
    assign w_rd_addr = i_cmd.rd_hit ? r_hit : r_scan[AW-1:0];

    // Table memory: loaded entries only are ever read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_loaded < DEPTH_C) begin
            r_mem_b[r_loaded[AW-1:0]] <= r_ib;
            r_mem_e[r_loaded[AW-1:0]] <= r_ie;
            r_mem_r[r_loaded[AW-1:0]] <= r_ir;
        end
        if (w_rd) begin
            r_rd_b <= r_mem_b[w_rd_addr];
            r_rd_e <= r_mem_e[w_rd_addr];
            r_rd_r <= r_mem_r[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_ib <= i_interval_start;
            r_ie <= i_interval_end;
            r_ir <= i_interval_rate;
            r_t  <= i_reading_time;
            r_tp <= i_time_present;
            r_en <= i_reading_energy;
            r_ep <= i_energy_present;
            r_tm <= i_reading_temp;
            r_pp <= i_temp_present;
        end
        if (i_cmd.check) r_gap <= w_gap;
        if (i_cmd.mul) begin
            r_pe <= 64'(r_en) * $signed({40'd0, r_rd_r});
            r_pt <= 64'(r_tm) * $signed({16'd0, r_gap});
        end
    end

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        begin
            s = a + b;
            if (!a[63] && !b[63] && s[63]) sat_add = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (a[63] && b[63] && !s[63]) sat_add = 64'h8000_0000_0000_0000;
            else sat_add = s;
        end
    endfunction

    logic signed [48:0] w_esum;
    logic [48:0]        w_elap;
    assign w_esum = 49'(r_esum) + 49'(r_en);
    assign w_elap = {1'b0, r_elap} + {1'b0, r_gap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_s  <= '0;
            r_win_e  <= '1;
            r_loaded <= '0;
            r_hit    <= '0;
            r_scan   <= '0;
            r_prev   <= '0;
            r_esum   <= '0;
            r_msum   <= '0;
            r_wsum   <= '0;
            r_elap   <= '0;
            r_acnt   <= '0;
            r_rcnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == irea_pkg::CFG_WINDOW_START) r_win_s <= i_cfg_data;
                else                                           r_win_e <= i_cfg_data;
            end
            if (i_cmd.load && r_loaded < DEPTH_C) r_loaded <= r_loaded + CW'(1);
            if (i_cmd.scan_clr) r_scan <= '0;
            if (i_cmd.scan_inc) r_scan <= r_scan + CW'(1);
            if (i_cmd.set_hit)  r_hit  <= r_scan[AW-1:0];
            if (i_cmd.reject && r_rcnt != '1) r_rcnt <= r_rcnt + 32'd1;
            if (i_cmd.move_prev) r_prev <= r_t;
            if (i_cmd.acc) begin
                if (w_esum[48] != w_esum[47]) r_esum <= w_esum[48] ? ~E_MAX : E_MAX;
                else                          r_esum <= w_esum[47:0];
                r_msum <= sat_add(r_msum, r_pe);
                r_wsum <= sat_add(r_wsum, r_pt);
                r_elap <= w_elap[48] || w_elap[47] ? E_MAX : w_elap[47:0];
                if (r_acnt != '1) r_acnt <= r_acnt + 32'd1;
            end
            if (i_cmd.clear) begin
                r_loaded <= '0;
                r_prev   <= '0;
                r_esum   <= '0;
                r_msum   <= '0;
                r_wsum   <= '0;
                r_elap   <= '0;
                r_acnt   <= '0;
                r_rcnt   <= '0;
            end
        end
    end

    logic               w_d1_done, w_d2_done;
    logic signed [63:0] w_q1, w_q2;
    logic               r_d1_seen, r_d2_seen;

    irea_div u_div_int (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_msum), .i_den(64'(r_esum)), .o_done(w_d1_done), .o_quo(w_q1)
    );
    irea_div u_div_tmp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_wsum), .i_den({16'd0, r_elap}), .o_done(w_d2_done), .o_quo(w_q2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_seen <= 1'b0;
            r_d2_seen <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_d1_seen <= 1'b0;
            r_d2_seen <= 1'b0;
        end else begin
            if (w_d1_done) r_d1_seen <= 1'b1;
            if (w_d2_done) r_d2_seen <= 1'b1;
        end
    end
    assign o_status.div_done = r_d1_seen && r_d2_seen;

    logic signed [63:0] w_int;
    logic signed [15:0] w_mean;
    logic               w_zero;
    always_comb begin
        w_int  = (!r_esum[47] && r_esum != '0) ? w_q1 : '0;
        if (r_elap == '0)                       w_mean = '0;
        else if (w_q2 > 64'sd32767)             w_mean = 16'sh7FFF;
        else if (w_q2 < -64'sd32768)            w_mean = 16'sh8000;
        else                                    w_mean = w_q2[15:0];
        w_zero = (r_win_e < r_win_s) || (r_loaded == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            if (w_zero) r_res <= '0;
            else        r_res <= {r_rcnt, r_acnt, w_mean, w_int, r_msum, r_esum};
        end
    end
    assign o_result = r_res;

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= DEPTH_C)
        else $error("load count beyond depth");
    a_hit_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_hit |-> (r_scan < r_loaded))
        else $error("last hit set past loaded entries");
    a_elap_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_elap[47])
        else $error("elapsed sum above saturation");
endmodule

// ----- design/interval_rated_energy_accumulator.sv -----
// Top level of the interval-rated energy accumulator.
// Depends on irea_pkg, irea_ctrl, irea_dp and irea_div.
// Load: the load state writes the entry. A reading ends at the checks, or on a
// last-hit match passes hit read, hit compare, multiply and accumulate; else the
// N-entry table is scanned, a read and a compare state per entry. Finish: the
// result follows the bit-serial 64-bit dividers; input reopens after it leaves.
// Reset is synchronous and active low; it clears sums, counts and control state
// and sets the window to its full range. The table needs no clearing pass.
module interval_rated_energy_accumulator #(
    parameter int TABLE_DEPTH = 128,
    parameter int TIME_BITS   = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], interval_start, interval_end, interval_rate[23:0],
    // reading_time, time_present, reading_energy[31:0], energy_present,
    // reading_temp[15:0], temp_present, zero fill
    input  logic [((3*TIME_BITS+77)+7)/8*8-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // total_energy[47:0], total_emission[63:0], emission_intensity[63:0],
    // mean_temperature[15:0], reading_count[31:0], skipped_count[31:0]
    output logic [255:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [39:0]  i_cfg_data
);
    localparam int T = TIME_BITS;

    irea_pkg::t_cmd    w_cmd;
    irea_pkg::t_status w_status;
    logic              w_take;

    assign o_cfg_ready = 1'b1;
    assign w_take      = s_axis_tvalid && s_axis_tready;

    irea_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_mode(s_axis_tdata[1:0]),
        .o_in_ready(s_axis_tready),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    irea_dp #(.TABLE_DEPTH(TABLE_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take),
        .i_interval_start(s_axis_tdata[2 +: T]),
        .i_interval_end(s_axis_tdata[2+T +: T]),
        .i_interval_rate(s_axis_tdata[2+2*T +: 24]),
        .i_reading_time(s_axis_tdata[26+2*T +: T]),
        .i_time_present(s_axis_tdata[26+3*T]),
        .i_reading_energy(s_axis_tdata[27+3*T +: 32]),
        .i_energy_present(s_axis_tdata[59+3*T]),
        .i_reading_temp(s_axis_tdata[60+3*T +: 16]),
        .i_temp_present(s_axis_tdata[76+3*T]),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_cmd(w_cmd), .o_status(w_status), .o_result(m_axis_tdata)
    );
endmodule
